// ===== rtl/mbm_pkg.sv =====
// Shared types and constants for the masked 3x3 binary morphology unit.
// No dependencies; used by the output queue, the top level and the testbench.
package mbm_pkg;

  localparam int DEFAULT_MAX_WIDTH = 1024;

  localparam int PIX_W         = 8;
  localparam int FRAME_WIDTH_W = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int MASK_W        = 9;
  localparam int ROW_W         = 12;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 13;

  localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [PIX_W-1:0]          WHITE        = 8'd255;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [MASK_W-1:0]         NEIGHBOR_MASK_RESET = 9'h1FF;

  // result queue between the pipeline and the output port
  localparam int QUEUE_DEPTH = 3;
  localparam int QUEUE_CNT_W = 2;
  localparam int QUEUE_PTR_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_CLEAN_MODE,
    CFG_NEIGHBOR_MASK
  } cfg_index_t;

  typedef enum logic {
    OP_PIXEL,
    OP_FLUSH
  } opcode_t;

  typedef enum logic {
    MODE_WHITEN,
    MODE_BLACKEN
  } clean_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } result_t;

endpackage

// ===== rtl/masked_binary_morphology_3x3_unit.sv =====
// Top level of the masked 3x3 binary morphology unit: counters, line memory,
// window registers and filter. Depends on mbm_pkg and mbm_out_queue.
//
// Usage: pixels enter in raster order on the in_ channel (in_opcode pixel),
// one item per clock while in_ready is high. Each accepted item is looked up
// in the line memory at the accepting edge and finished in the next cycle,
// where its result (if any) enters a three-entry result queue, whose
// registered count raises out_valid. Sustained rate is one item per clock
// while out_ready stays high, set by the
// single read and single write port of the line memory, which a pixel uses
// once each. In image terms a pixel's result leaves once the pixel one line
// and one column later has been accepted; after the last pixel of a frame,
// frame width plus one flush items (frame width alone for a one-line frame)
// drain the rest, frame_end on the last one.
// Reset clears the counters and loads the default registers; the line memory
// is not cleared, since no result reads an entry before the frame writes it.
// When out_ready is low, results collect in the queue and in_ready drops
// once the queue and the item in flight would fill it. Writing frame_width
// or frame_height restarts the frame and drops pending pixels.
module masked_binary_morphology_3x3_unit #(
  parameter int MAX_WIDTH = mbm_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic [mbm_pkg::PIX_W-1:0]          in_pixel_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mbm_pkg::PIX_W-1:0]          out_pixel_out,
  output logic                               out_frame_end,
  input  logic                               cfg_wr_en,
  input  logic [mbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > mbm_pkg::FRAME_WIDTH_W) ?
                      $clog2(MAX_WIDTH + 1) : mbm_pkg::FRAME_WIDTH_W;
  localparam int PW = WW + 1;
  localparam int PXW = mbm_pkg::PIX_W;
  localparam int HW = mbm_pkg::FRAME_HEIGHT_W;
  localparam int RW = mbm_pkg::ROW_W;
  localparam logic [WW-1:0] MaxW = WW'(MAX_WIDTH);
  // window position of the middle row, right column
  localparam int MidRight = 5;

  // configuration registers
  logic [mbm_pkg::FRAME_WIDTH_W-1:0] frame_width_r;
  logic [HW-1:0]                     frame_height_r;
  logic                              clean_mode_r;
  logic [mbm_pkg::MASK_W-1:0]        neighbor_mask_r;
  logic                              restart;

  // frame position
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic          done_r, done_nxt;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] c0;
  logic [RW-1:0] r0;
  logic [PW-1:0] p0;
  logic [WW-1:0] c_ext;
  logic          is_flush, accept, s0_go;
  logic          px_edge, px_ctr, px_border, col_last, row_last;
  logic          fl_ok, fl_upper;
  logic [WW-1:0] fl_addr_w;
  logic [CW-1:0] ra;

  // finishing stage
  logic           s1_v_r;
  logic           s1_pix_r;
  logic [CW-1:0]  s1_addr_r;
  logic [PXW-1:0] s1_data_r;
  logic           s1_edge_r, s1_ctr_r, s1_border_r, s1_upper_r, s1_end_r;
  logic           s1_we;
  logic [2*PXW-1:0] s1_wdata;

  logic [2*PXW-1:0] line_mem [MAX_WIDTH];
  logic [2*PXW-1:0] rdata_r;
  logic             fwd_hit_r, fwd_hit_nxt;
  logic [2*PXW-1:0] fwd_data_r;
  logic [2*PXW-1:0] rd;
  logic [PXW-1:0]   top, mid;

  logic [8:0][PXW-1:0] win_r, win_nxt;
  logic [PXW-1:0]      filt;

  mbm_pkg::result_t                   res;
  logic                               push;
  logic [mbm_pkg::QUEUE_CNT_W-1:0]    q_count;
  mbm_pkg::result_t                   q_out;

  function automatic logic [PXW-1:0] filter_center(
    input logic [8:0][PXW-1:0]      win,
    input logic [mbm_pkg::MASK_W-1:0] mask,
    input logic                     mode
  );
    logic           any_dark;
    logic [PXW-1:0] center;
    logic [PXW-1:0] result;
    any_dark = 1'b0;
    center   = win[4];
    for (int k = 0; k < 9; k++) begin
      if (mask[k] && (win[k] != mbm_pkg::WHITE)) begin
        any_dark = 1'b1;
      end
    end
    result = center;
    if (mode == mbm_pkg::MODE_WHITEN) begin
      if (center == '0 && !any_dark) begin
        result = mbm_pkg::WHITE;
      end
    end else begin
      if (center != '0 && any_dark) begin
        result = '0;
      end
    end
    return result;
  endfunction

  // ---------------------------------------------------------------- config
  assign restart = cfg_wr_en &&
                   ((mbm_pkg::cfg_index_t'(cfg_index) == mbm_pkg::CFG_FRAME_WIDTH) ||
                    (mbm_pkg::cfg_index_t'(cfg_index) == mbm_pkg::CFG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= mbm_pkg::FRAME_WIDTH_RESET;
      frame_height_r  <= mbm_pkg::FRAME_HEIGHT_RESET;
      clean_mode_r    <= mbm_pkg::MODE_WHITEN;
      neighbor_mask_r <= mbm_pkg::NEIGHBOR_MASK_RESET;
    end else if (cfg_wr_en) begin
      unique case (mbm_pkg::cfg_index_t'(cfg_index))
        mbm_pkg::CFG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata[mbm_pkg::FRAME_WIDTH_W-1:0];
        mbm_pkg::CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[HW-1:0];
        mbm_pkg::CFG_CLEAN_MODE:    clean_mode_r    <= cfg_wdata[0];
        mbm_pkg::CFG_NEIGHBOR_MASK: neighbor_mask_r <= cfg_wdata[mbm_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- accept stage
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (WW'(frame_width_r) > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HW'(1);
    end else if (frame_height_r > mbm_pkg::HEIGHT_LIMIT) begin
      h_eff = mbm_pkg::HEIGHT_LIMIT;
    end else begin
      h_eff = frame_height_r;
    end
  end

  // a pixel after a finished frame starts the next one
  assign c0 = done_r ? '0 : col_r;
  assign r0 = done_r ? '0 : row_r;
  assign p0 = done_r ? '0 : pend_r;
  assign c_ext = WW'(c0);

  assign is_flush = (in_opcode == mbm_pkg::OP_FLUSH);
  assign accept   = in_valid && in_ready;

  assign px_edge   = (c0 == '0) && (r0 >= RW'(2));
  assign px_ctr    = (c0 != '0) && (r0 != '0);
  assign px_border = (c0 == CW'(1)) || (r0 == RW'(1));
  assign col_last  = (c_ext + WW'(1)) >= w_eff;
  assign row_last  = (HW'(r0) + HW'(1)) >= h_eff;

  assign fl_ok     = done_r && (pend_r != '0);
  assign fl_upper  = pend_r > PW'(w_eff);
  assign fl_addr_w = fl_upper ? (w_eff - WW'(1)) : (w_eff - pend_r[WW-1:0]);

  assign ra    = is_flush ? fl_addr_w[CW-1:0] : c0;
  assign s0_go = accept && (!is_flush || fl_ok);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    done_nxt = done_r;
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      pend_nxt = '0;
      done_nxt = 1'b0;
    end else if (accept && !is_flush) begin
      if (col_last) begin
        col_nxt  = '0;
        row_nxt  = row_last ? r0 : r0 + 1'b1;
        done_nxt = row_last;
      end else begin
        col_nxt  = CW'(c_ext + WW'(1));
        row_nxt  = r0;
        done_nxt = 1'b0;
      end
      pend_nxt = (px_edge || px_ctr) ? p0 : p0 + 1'b1;
    end else if (accept && fl_ok) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
      done_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s0_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go) begin
      s1_pix_r    <= !is_flush;
      s1_addr_r   <= ra;
      s1_data_r   <= in_pixel_in;
      s1_edge_r   <= px_edge;
      s1_ctr_r    <= px_ctr;
      s1_border_r <= px_border;
      s1_upper_r  <= fl_upper;
      s1_end_r    <= (pend_r == PW'(1));
    end
  end

  // ------------------------------------------------------- line memory
  // upper line in the high byte, middle line in the low byte
  assign s1_we    = s1_v_r && s1_pix_r;
  assign s1_wdata = {mid, s1_data_r};

  always_ff @(posedge clk) begin
    if (s1_we) begin
      line_mem[s1_addr_r] <= s1_wdata;
    end
    rdata_r <= line_mem[ra];
  end

  // forward a write that lands in the same cycle as the read of that entry
  assign fwd_hit_nxt = s1_we && s0_go && (ra == s1_addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fwd_hit_nxt) begin
      fwd_data_r <= s1_wdata;
    end
  end

  assign rd  = fwd_hit_r ? fwd_data_r : rdata_r;
  assign top = rd[2*PXW-1:PXW];
  assign mid = rd[PXW-1:0];

  // ------------------------------------------------------- window + filter
  always_comb begin
    for (int row = 0; row < 3; row++) begin
      win_nxt[row*3]     = win_r[row*3 + 1];
      win_nxt[row*3 + 1] = win_r[row*3 + 2];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = s1_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_we) begin
      win_r <= win_nxt;
    end
  end

  assign filt = filter_center(win_nxt, neighbor_mask_r, clean_mode_r);

  always_comb begin
    if (s1_pix_r) begin
      // the line-end pixel and border centers both come from the middle-right slot
      res.pixel_out = (s1_edge_r || s1_border_r) ? win_r[MidRight] : filt;
      res.frame_end = 1'b0;
      push          = s1_v_r && (s1_edge_r || s1_ctr_r);
    end else begin
      res.pixel_out = s1_upper_r ? top : mid;
      res.frame_end = s1_end_r;
      push          = s1_v_r;
    end
  end

  // ------------------------------------------------------- output
  mbm_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .count     (q_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_out)
  );

  assign out_pixel_out = q_out.pixel_out;
  assign out_frame_end = q_out.frame_end;

  // hold off when the queue plus the item in flight could fill it
  assign in_ready = ({1'b0, q_count} + {2'b00, s1_v_r}) <=
                    3'(mbm_pkg::QUEUE_DEPTH - 1);

  a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < w_eff)
    else $error("column count beyond the line width");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= (PW'(w_eff) + PW'(1)))
    else $error("pending count beyond one line plus one pixel");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> (s1_v_r && $past(s1_v_r && s1_pix_r)))
    else $error("forwarded line data without a pixel write before it");

endmodule

// ===== rtl/mbm_out_queue.sv =====
// Three-entry result queue that parts the pipeline from the output handshake.
// Depends on mbm_pkg for the result type and queue sizing.
module mbm_out_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  mbm_pkg::result_t                    push_data,
  output logic [mbm_pkg::QUEUE_CNT_W-1:0]     count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mbm_pkg::result_t                    out_data
);

  localparam logic [mbm_pkg::QUEUE_CNT_W-1:0] Full = mbm_pkg::QUEUE_CNT_W'(mbm_pkg::QUEUE_DEPTH);
  localparam logic [mbm_pkg::QUEUE_PTR_W-1:0] LastPtr =
    mbm_pkg::QUEUE_PTR_W'(mbm_pkg::QUEUE_DEPTH - 1);

  mbm_pkg::result_t                   q_r [mbm_pkg::QUEUE_DEPTH];
  logic [mbm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mbm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mbm_pkg::QUEUE_CNT_W-1:0]    count_r, count_nxt;
  logic                               pop;

  assign out_valid = (count_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign count     = count_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == Full && !pop) |-> !push)
    else $error("result queue overflow");

  a_empty_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && !push) |=> !out_valid)
    else $error("result queue shows an item that was never pushed");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for masked_binary_morphology_3x3_unit: a scoreboard class predicts
// each filtered pixel from the raster stream, and tasks drive pixels, flushes and registers.
// Depends on mbm_pkg and the unit's RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mbm_pkg::*;

  localparam int MAX_W = DEFAULT_MAX_WIDTH;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PIXELS = 650;

  // Predicts the filtered stream and holds the pixels still due from the unit.
  class morph_checker;
    logic [FRAME_WIDTH_W-1:0]  width_reg;
    logic [FRAME_HEIGHT_W-1:0] height_reg;
    clean_mode_t               mode_reg;
    logic [MASK_W-1:0]         mask_reg;
    logic [PIX_W-1:0]          upper_line [MAX_W];
    logic [PIX_W-1:0]          middle_line [MAX_W];
    logic [PIX_W-1:0]          win [3][3];
    int unsigned               col_pos;
    int unsigned               row_pos;
    int unsigned               pending_pixels;
    bit                        frame_done;
    result_t                   due_pixels [$];
    int                        failures;

    function new();
      width_reg  = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      mode_reg   = MODE_WHITEN;
      mask_reg   = NEIGHBOR_MASK_RESET;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      failures = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      col_pos        = 0;
      row_pos        = 0;
      pending_pixels = 0;
      frame_done     = 1'b0;
    endfunction

    function int unsigned line_len();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned frame_lines();
      if (height_reg == 0) return 1;
      if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return height_reg;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH: begin
          width_reg = val[FRAME_WIDTH_W-1:0];
          restart_frame();
        end
        CFG_FRAME_HEIGHT: begin
          height_reg = val[FRAME_HEIGHT_W-1:0];
          restart_frame();
        end
        CFG_CLEAN_MODE:    mode_reg = clean_mode_t'(val[0]);
        CFG_NEIGHBOR_MASK: mask_reg = val[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] filtered_center();
      logic [PIX_W-1:0] center;
      bit               dark;
      center = win[1][1];
      dark   = 1'b0;
      for (int k = 0; k < 9; k++) begin
        if (mask_reg[k] && win[k / 3][k % 3] != WHITE) dark = 1'b1;
      end
      if (mode_reg == MODE_WHITEN) begin
        if (center == 0 && !dark) return WHITE;
      end else begin
        if (center != 0 && dark) return '0;
      end
      return center;
    endfunction

    function void note_item(opcode_t op, logic [PIX_W-1:0] px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      int unsigned      r;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      result_t          res;
      bit               produced;
      w = line_len();
      h = frame_lines();
      if (op == OP_FLUSH) begin
        if (!frame_done || pending_pixels == 0) return;
        res.pixel_out = (pending_pixels > w) ? upper_line[w - 1]
                                             : middle_line[w - pending_pixels];
        pending_pixels--;
        res.frame_end = (pending_pixels == 0);
        due_pixels.push_back(res);
        return;
      end
      if (frame_done) restart_frame();
      c = col_pos;
      r = row_pos;
      produced = 1'b0;
      res = '0;
      // last pixel of line r-2 is a border pixel and leaves at column 0
      if (c == 0 && r >= 2) begin
        res.pixel_out = win[1][2];
        produced = 1'b1;
      end
      top = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = px;
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = px;
      // window center is pixel (c-1, r-1)
      if (c >= 1 && r >= 1) begin
        res.pixel_out = (c == 1 || r == 1) ? win[1][1] : filtered_center();
        produced = 1'b1;
      end
      if (produced) due_pixels.push_back(res);
      else pending_pixels++;
      if (c + 1 >= w) begin
        col_pos = 0;
        if (r + 1 >= h) frame_done = 1'b1;
        else row_pos = r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [PIX_W-1:0] px, logic fe);
      result_t want;
      if (due_pixels.size() == 0) begin
        note_failure($sformatf("unexpected pixel %0d frame_end %0b", px, fe));
        return;
      end
      want = due_pixels.pop_front();
      if (px !== want.pixel_out || fe !== want.frame_end)
        note_failure($sformatf("pixel expected %0d got %0d, frame_end expected %0b got %0b",
                               want.pixel_out, px, want.frame_end, fe));
    endfunction

    function int outstanding();
      return due_pixels.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_opcode;
  logic [PIX_W-1:0]       in_pixel_in;
  logic                   out_valid;
  logic                   out_ready;
  logic [PIX_W-1:0]       out_pixel_out;
  logic                   out_frame_end;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  morph_checker sb = new();
  bit           quiet = 1'b0;
  bit           hold_req = 1'b0;
  int unsigned  pixels_sent = 0;
  int unsigned  cycle_count = 0;

  masked_binary_morphology_3x3_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL masked_binary_morphology_3x3_unit");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(opcode_t'(in_opcode), in_pixel_in);
      if (out_valid && out_ready) sb.check_result(out_pixel_out, out_frame_end);
    end
  end

  // mostly short stalls, a few long ones
  function automatic int unsigned stall_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(16, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(int white_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < white_pct) return WHITE;
    if (pick < 90) return '0;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned len;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        len = stall_len();
        out_ready <= 1'b0;
        repeat (len) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Valid stays high across back-to-back items; lower it only for a gap.
  task automatic send_item(input opcode_t op, input logic [PIX_W-1:0] px);
    int unsigned gap;
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_pixel_in <= px;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 40) gap = stall_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering items, then wait for every due pixel and the pipeline tail.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [FRAME_WIDTH_W-1:0] wr,
                           input logic [FRAME_HEIGHT_W-1:0] hr,
                           input clean_mode_t m, input logic [MASK_W-1:0] mk);
    cfg_wr_en <= 1'b1;
    put_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(wr));
    put_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(hr));
    put_reg(CFG_CLEAN_MODE, CFG_DATA_W'(m));
    put_reg(CFG_NEIGHBOR_MASK, CFG_DATA_W'(mk));
    cfg_wr_en <= 1'b0;
  endtask

  // One frame of pixels and its flushes; 0 < stop < w*h cuts the frame short, no flushes.
  task automatic run_frame(input int unsigned w, input int unsigned h, input int white_pct,
                           input int unsigned stop);
    int unsigned total;
    int unsigned flushes;
    int          pick;
    total = w * h;
    if (stop == 0 || stop > total) stop = total;
    for (int unsigned n = 0; n < stop; n++) begin
      // a flush in mid-frame is ignored
      if ($urandom_range(0, 49) == 0) send_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
      send_item(OP_PIXEL, pick_pixel(white_pct));
      pixels_sent++;
    end
    if (stop < total) return;
    pick = $urandom_range(0, 9);
    if (pick < 7) flushes = w + 1 + ((pick == 0) ? $urandom_range(1, 2) : 0);
    else flushes = $urandom_range(0, w);
    repeat (flushes) send_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input logic [FRAME_WIDTH_W-1:0] wr,
                           input logic [FRAME_HEIGHT_W-1:0] hr,
                           input int frames, input int unsigned last_len, input bit hold);
    int unsigned w;
    int unsigned h;
    clean_mode_t m;
    logic [MASK_W-1:0] mk;
    int white_pct;
    w = (wr == 0) ? 1 : ((wr > MAX_W) ? MAX_W : wr);
    h = (hr == 0) ? 1 : ((hr > HEIGHT_LIMIT) ? HEIGHT_LIMIT : hr);
    m = clean_mode_t'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       mk = '0;
      1, 2, 3: mk = NEIGHBOR_MASK_RESET;
      default: mk = MASK_W'($urandom_range(0, 511));
    endcase
    white_pct = $urandom_range(40, 85);
    settle();
    configure(wr, hr, m, mk);
    quiet = !hold && ($urandom_range(0, 3) == 0);
    if (hold) hold_req = 1'b1;
    for (int f = 0; f < frames; f++)
      run_frame(w, h, white_pct, (f == frames - 1) ? last_len : 0);
  endtask

  task automatic run_directed();
    logic [PIX_W-1:0] frame_a [9];
    logic [PIX_W-1:0] frame_b [9];
    frame_a = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    frame_b = '{8'd255, 8'd7, 8'd255, 8'd255, 8'd200, 8'd255, 8'd255, 8'd255, 8'd255};
    settle();
    // lone black pixel in a white field stays black: the full mask counts the center as dark
    configure(11'd3, 13'd3, MODE_WHITEN, NEIGHBOR_MASK_RESET);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(OP_FLUSH, 8'hFF);
      send_item(OP_PIXEL, frame_a[i]);
    end
    repeat (4) send_item(OP_FLUSH, 8'h00);
    settle();
    // center excluded from the mask; one dark neighbor blackens it
    configure(11'd3, 13'd3, MODE_BLACKEN, 9'h1EF);
    for (int i = 0; i < 9; i++) send_item(OP_PIXEL, frame_b[i]);
    repeat (5) send_item(OP_FLUSH, 8'hA5);
  endtask

  task automatic run_random();
    logic [FRAME_WIDTH_W-1:0]  wr;
    logic [FRAME_HEIGHT_W-1:0] hr;
    int                        frames;
    int unsigned               last_len;
    bit                        hold;
    bit                        hold_done;
    int                        pick;
    hold_done = 1'b0;
    while (pixels_sent < RANDOM_PIXELS || !hold_done) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) wr = '0;
      else if (pick < 85) wr = FRAME_WIDTH_W'($urandom_range(1, 12));
      else wr = FRAME_WIDTH_W'($urandom_range(13, 40));
      pick = $urandom_range(0, 99);
      if (pick < 5) hr = '0;
      else if (pick < 90) hr = FRAME_HEIGHT_W'($urandom_range(1, 8));
      else hr = FRAME_HEIGHT_W'($urandom_range(9, 16));
      frames = $urandom_range(1, 3);
      last_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : 0;
      hold = 1'b0;
      if (!hold_done && pixels_sent >= 400) begin
        wr = 11'd12;
        hr = 13'd8;
        frames = 1;
        last_len = 0;
        hold = 1'b1;
        hold_done = 1'b1;
      end
      run_phase(wr, hr, frames, last_len, hold);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_PIXEL;
    in_pixel_in <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= CFG_FRAME_WIDTH;
    cfg_wdata   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    // register extremes: widest line clamps to the line store and wraps into a
    // second line, tallest frame cut short
    run_phase(11'd2047, 13'd2, 1, 1026, 1'b0);
    run_phase(11'd1, 13'd8191, 1, 60, 1'b0);
    pixels_sent = 0;
    run_random();
    settle();
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("PASS masked_binary_morphology_3x3_unit");
    end else begin
      $display("FAIL masked_binary_morphology_3x3_unit");
    end
    $finish;
  end

endmodule
